// ----- hdl/lps_pkg.sv -----
// Shared types, request codes and pattern ROM for the LED pattern sequencer.
`default_nettype none

package lps_pkg;

	localparam int LPS_CHANNELS      = 4;
	localparam int LPS_PATTERN_COUNT = 10;

	localparam int ROM_PATTERNS = 10;
	localparam int MAX_STEPS    = 4;
	localparam int DUR_W        = 10;
	localparam int STEP_W       = 3;
	localparam int PAT_W        = 4;
	localparam int REP_W        = 8;
	localparam int PINS_W       = 4;

	localparam logic [DUR_W-1:0] ELAPSED_MAX = '1;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_ON    = 2'd2;
	localparam logic [1:0] REQ_OFF   = 2'd3;

	localparam logic [STEP_W-1:0] ROM_LEN [ROM_PATTERNS] = '{
		3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
	};

	localparam logic [DUR_W-1:0] ROM_ON [ROM_PATTERNS][MAX_STEPS] = '{
		'{10'd150, 10'd0,   10'd0,   10'd0},
		'{10'd10,  10'd0,   10'd0,   10'd0},
		'{10'd200, 10'd0,   10'd0,   10'd0},
		'{10'd80,  10'd80,  10'd0,   10'd0},
		'{10'd0,   10'd80,  10'd80,  10'd0},
		'{10'd50,  10'd50,  10'd50,  10'd0},
		'{10'd70,  10'd200, 10'd0,   10'd0},
		'{10'd90,  10'd60,  10'd60,  10'd0},
		'{10'd70,  10'd50,  10'd110, 10'd0},
		'{10'd50,  10'd100, 10'd200, 10'd50}
	};

	localparam logic [DUR_W-1:0] ROM_OFF [ROM_PATTERNS][MAX_STEPS] = '{
		'{10'd150, 10'd0,   10'd0,   10'd0},
		'{10'd100, 10'd0,   10'd0,   10'd0},
		'{10'd200, 10'd0,   10'd0,   10'd0},
		'{10'd120, 10'd120, 10'd800, 10'd0},
		'{10'd800, 10'd120, 10'd120, 10'd0},
		'{10'd50,  10'd50,  10'd200, 10'd0},
		'{10'd40,  10'd60,  10'd0,   10'd0},
		'{10'd40,  10'd25,  10'd35,  10'd0},
		'{10'd30,  10'd20,  10'd40,  10'd0},
		'{10'd100, 10'd30,  10'd30,  10'd0}
	};

	typedef struct packed {
		logic              active;
		logic              pin;
		logic              on_phase;
		logic [STEP_W-1:0] step;
		logic [PAT_W-1:0]  pat;
		logic [REP_W-1:0]  target;
		logic [REP_W-1:0]  done;
		logic [DUR_W-1:0]  elapsed;
	} lps_chan_state_t;

	// decoded request as seen by one channel
	typedef struct packed {
		logic [1:0]       req;
		logic             hit;
		logic [PAT_W-1:0] pid;
		logic [REP_W-1:0] rep;
	} lps_cmd_t;

	typedef struct packed {
		logic pin;
		logic active;
	} lps_chan_stat_t;

	function automatic logic [STEP_W-1:0] rom_len(input logic [PAT_W-1:0] pat);
		logic [STEP_W-1:0] len;
		len = '0;
		if (pat < PAT_W'(ROM_PATTERNS)) begin
			len = ROM_LEN[pat];
		end
		return len;
	endfunction

	function automatic logic [DUR_W-1:0] rom_dur(input logic [PAT_W-1:0] pat,
		input logic [1:0] idx, input logic on);
		logic [DUR_W-1:0] dur;
		dur = '0;
		if (pat < PAT_W'(ROM_PATTERNS)) begin
			dur = on ? ROM_ON[pat][idx] : ROM_OFF[pat][idx];
		end
		return dur;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/lps_if.sv -----
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface lps_req_if
	import lps_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [1:0]       channel;
	logic [PAT_W-1:0] pattern_id;
	logic [REP_W-1:0] repeat_count;

	modport source (output valid, req_type, channel, pattern_id, repeat_count,
		input ready);
	modport sink (input valid, req_type, channel, pattern_id, repeat_count,
		output ready);
endinterface

interface lps_rsp_if
	import lps_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [PINS_W-1:0] pin_levels;
	logic [PINS_W-1:0] active_mask;

	modport source (output valid, pin_levels, active_mask, input ready);
	modport sink (input valid, pin_levels, active_mask, output ready);
endinterface

`default_nettype wire

// ----- hdl/lps_chan.sv -----
// One output channel: state registers and the per-item update logic.
`default_nettype none

module lps_chan
	import lps_pkg::*;
#(
	parameter int PATTERN_COUNT = LPS_PATTERN_COUNT
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           upd,
	input  wire lps_cmd_t       cmd,
	output      lps_chan_stat_t stat_nxt
);

	lps_chan_state_t cur_q;
	lps_chan_state_t nxt;

	always_comb begin
		logic [STEP_W-1:0] idx;
		logic [REP_W-1:0]  done_inc;
		logic [DUR_W-1:0]  el;
		logic [DUR_W-1:0]  dur;
		logic              stop;

		nxt      = cur_q;
		idx      = cur_q.step;
		done_inc = cur_q.done + REP_W'(1);
		el       = cur_q.elapsed;
		dur      = '0;
		stop     = 1'b0;

		case (cmd.req)
			REQ_TICK: begin
				if (cur_q.active) begin
					if (cur_q.pat >= PAT_W'(ROM_PATTERNS)) begin
						nxt.active = 1'b0;
						nxt.pin    = 1'b0;
					end else begin
						// past the last step: wrap, and count one pass when a target is set
						if (cur_q.step >= rom_len(cur_q.pat)) begin
							idx      = '0;
							nxt.step = '0;
							if (cur_q.target != '0) begin
								nxt.done = done_inc;
								stop     = (done_inc >= cur_q.target);
							end
						end
						if (stop) begin
							nxt.active = 1'b0;
							nxt.pin    = 1'b0;
						end else begin
							dur = rom_dur(cur_q.pat, idx[1:0], cur_q.on_phase);
							if (el != ELAPSED_MAX) begin
								el = el + DUR_W'(1);
							end
							if (el >= dur) begin
								el = '0;
								if (cur_q.on_phase) begin
									nxt.on_phase = 1'b0;
									nxt.pin      = 1'b0;
								end else begin
									nxt.on_phase = 1'b1;
									nxt.pin      = 1'b1;
									nxt.step     = idx + STEP_W'(1);
								end
							end
							nxt.elapsed = el;
						end
					end
				end
			end
			REQ_START: begin
				if (cmd.hit && ({1'b0, cmd.pid} < (PAT_W+1)'(PATTERN_COUNT))
					&& (cmd.pid < PAT_W'(ROM_PATTERNS))) begin
					nxt.pat      = cmd.pid;
					nxt.step     = '0;
					nxt.done     = '0;
					nxt.target   = cmd.rep;
					nxt.elapsed  = '0;
					nxt.on_phase = 1'b1;
					nxt.active   = 1'b1;
					nxt.pin      = 1'b1;
				end
			end
			REQ_ON: begin
				if (cmd.hit) begin
					nxt.pin    = 1'b1;
					nxt.active = 1'b0;
				end
			end
			REQ_OFF: begin
				if (cmd.hit) begin
					nxt.pin    = 1'b0;
					nxt.active = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (upd) begin
			cur_q <= nxt;
		end
	end

	assign stat_nxt.pin    = nxt.pin;
	assign stat_nxt.active = nxt.active;

endmodule

`default_nettype wire

// ----- hdl/led_pattern_sequencer_top.sv -----
// Top level of the LED pattern sequencer: input stage, channel array, result stage.
// A request item accepted into the request register moves on to the result register.
// Throughput: one item per cycle while rsp.ready stays high; the request register and
// the result register form a two-stage pipeline, so a new item is taken while a result
// waits. The rate is set by the single channel-update pass between the two registers.
// Reset (arst_n low, asynchronous) clears every channel's state and both valid flags.
`default_nettype none

module led_pattern_sequencer_top
	import lps_pkg::*;
#(
	parameter int CHANNELS      = LPS_CHANNELS,
	parameter int PATTERN_COUNT = LPS_PATTERN_COUNT
) (
	input wire logic clk,
	input wire logic arst_n,
	lps_req_if.sink   req,
	lps_rsp_if.source rsp
);

	// ---------------------------------------------------------------
	// Request stage: holds one accepted item until the channels take it.
	// ---------------------------------------------------------------
	logic             valid_s1;
	logic [1:0]       req_type_s1;
	logic [1:0]       channel_s1;
	logic [PAT_W-1:0] pattern_id_s1;
	logic [REP_W-1:0] repeat_count_s1;

	logic rsp_valid_q;
	logic advance;
	logic req_fire;

	// the item in stage 1 moves on when the result register is free or drained
	assign advance  = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_fire = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_type_s1     <= req.req_type;
			channel_s1      <= req.channel;
			pattern_id_s1   <= req.pattern_id;
			repeat_count_s1 <= req.repeat_count;
		end
	end

	// ---------------------------------------------------------------
	// Channel array: each channel updates its own state in parallel.
	// Only the first four channels can be addressed by the 2-bit field,
	// and only those four appear in the result.
	// ---------------------------------------------------------------
	lps_chan_stat_t stat_nxt [CHANNELS];
	logic [PINS_W-1:0] pins_nxt;
	logic [PINS_W-1:0] act_nxt;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		lps_cmd_t cmd;

		assign cmd.req = req_type_s1;
		assign cmd.pid = pattern_id_s1;
		assign cmd.rep = repeat_count_s1;
		if (i < PINS_W) begin : g_addr
			assign cmd.hit = (channel_s1 == 2'(i));
		end else begin : g_noaddr
			assign cmd.hit = 1'b0;
		end

		lps_chan #(
			.PATTERN_COUNT(PATTERN_COUNT)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.upd     (advance),
			.cmd     (cmd),
			.stat_nxt(stat_nxt[i])
		);
	end

	for (genvar i = 0; i < PINS_W; i++) begin : g_pack
		if (i < CHANNELS) begin : g_used
			assign pins_nxt[i] = stat_nxt[i].pin;
			assign act_nxt[i]  = stat_nxt[i].active;
		end else begin : g_unused
			assign pins_nxt[i] = 1'b0;
			assign act_nxt[i]  = 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Result stage: one result item per request item.
	// ---------------------------------------------------------------
	logic [PINS_W-1:0] pins_q;
	logic [PINS_W-1:0] act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pins_q <= pins_nxt;
			act_q  <= act_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.pin_levels  = pins_q;
	assign rsp.active_mask = act_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("advanced item did not produce a result");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && rsp_valid_q && !rsp.ready))
		else $error("request side stalled without a full pipeline");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && valid_s1) |-> advance)
		else $error("stage 1 item overwritten before it moved on");

endmodule

`default_nettype wire
